// ===== hdl/sklru_pkg.sv =====
package sklru_pkg;

  localparam int FIELD_W  = 13;
  localparam int CAP_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;
  localparam int REG_IDX_W = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_CHECK_ENABLE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NOMINAL_WIDTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NOMINAL_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CORNER_RADIUS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY       = 3'd4;

  localparam logic [FIELD_W-1:0] NOMINAL_RST  = 13'd32;
  localparam logic [FIELD_W-1:0] RADIUS_RST   = 13'd8;
  localparam logic [CAP_W-1:0]   CAPACITY_RST = 5'd10;

  typedef struct packed {
    logic [FIELD_W-1:0] img_width;
    logic [FIELD_W-1:0] img_height;
  } in_req_t;

  typedef struct packed {
    logic               accepted;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_width;
    logic [FIELD_W-1:0] evicted_height;
  } out_rsp_t;

  typedef enum logic {
    OP_EQ,   // both field pairs equal
    OP_DEV   // |a_w - b_w| > lim
  } cmp_op_t;

  typedef struct packed {
    cmp_op_t            op;
    logic [FIELD_W-1:0] a_w;
    logic [FIELD_W-1:0] a_h;
    logic [FIELD_W-1:0] b_w;
    logic [FIELD_W-1:0] b_h;
    logic [FIELD_W-1:0] lim;
  } cmp_req_t;

endpackage

// ===== hdl/sklru_cmp_unit.sv =====
// Shared compare unit: size match or deviation check.
module sklru_cmp_unit (
  input  sklru_pkg::cmp_req_t req,
  output logic                flag
);

  localparam int FW = sklru_pkg::FIELD_W;

  logic [FW:0]   diff;
  logic [FW-1:0] mag;

  assign diff = {1'b0, req.a_w} - {1'b0, req.b_w};
  assign mag  = diff[FW] ? FW'(-diff) : diff[FW-1:0];

  always_comb begin
    unique case (req.op)
      sklru_pkg::OP_EQ:  flag = (req.a_w == req.b_w) && (req.a_h == req.b_h);
      sklru_pkg::OP_DEV: flag = (mag > req.lim);
      default:           flag = 1'b0;
    endcase
  end

endmodule

// ===== hdl/sklru_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module sklru_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 26
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/size_keyed_lru_cache_controller.sv =====
// Size-keyed LRU cache controller.
// Input channel (in_valid / in_stall / in_data) takes one request per image size.
// A request is taken when in_valid is high and in_stall is low; in_stall stays high
// while a request is being worked on or the table is being trimmed.
// Result channel (out_valid / out_stall / out_data) gives one result per request
// from an output register; out_data holds while out_stall is high. The next request
// is taken as soon as its result is parked there, even if the receiver stalls.
// Timing: a request's result is set by the slot walk, which reads the entry RAM one
// slot per cycle through the shared compare unit, after the width and height checks
// when size checking is enabled; a rejected size skips the walk.
// Flow: a new request is taken only once the last result is parked, which waits
// only while a parked result is still stalled.
// Config (APB, pready tied high): writes at byte address 4*index. Changing check
// enable, nominal size or radius clears the table. Lowering capacity drops the
// oldest entries, one per cycle, with in_stall high meanwhile.
// Reset (rst_n, synchronous): registers to defaults, table empty, no result pending.
module size_keyed_lru_cache_controller #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sklru_pkg::in_req_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sklru_pkg::out_rsp_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sklru_pkg::APB_AW-1:0]      paddr,
  input  logic [sklru_pkg::APB_DW-1:0]      pwdata,
  output logic [sklru_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);

  localparam int FW = sklru_pkg::FIELD_W;
  localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > sklru_pkg::CAP_W) ? CW : sklru_pkg::CAP_W;
  localparam int KW = SW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK_W, S_CHK_H, S_WALK, S_UPDATE, S_RESULT, S_TRIM
  } state_t;

  state_t state_r;

  // config registers
  logic                         check_en_r;
  logic [FW-1:0]                nom_w_r;
  logic [FW-1:0]                nom_h_r;
  logic [FW-1:0]                radius_r;
  logic [sklru_pkg::CAP_W-1:0]  cap_r;

  // table control
  logic [MAX_ENTRIES-1:0] occ_r;
  logic [SW-1:0]          rank_r [MAX_ENTRIES];  // 0 = oldest
  logic [CW-1:0]          count_r;

  // current request and walk results
  sklru_pkg::in_req_t req_r;
  logic [KW-1:0]      k_r;
  logic               pipe_vld_r;
  logic [SW-1:0]      pipe_idx_r;
  logic               hit_r;
  logic [SW-1:0]      hit_slot_r;
  logic [SW-1:0]      hit_rank_r;
  logic               free_found_r;
  logic [SW-1:0]      free_slot_r;
  logic [SW-1:0]      old_slot_r;
  logic [FW-1:0]      old_w_r;
  logic [FW-1:0]      old_h_r;

  sklru_pkg::out_rsp_t res_r;
  sklru_pkg::out_rsp_t out_data_r;
  logic                out_valid_r;

  // datapath
  logic                             cfg_wr;
  logic [sklru_pkg::REG_IDX_W-1:0]  cfg_idx;
  logic [sklru_pkg::CAP_W-1:0]      cap_wr_val;
  logic [EW-1:0]                    eff_cap;
  logic [EW-1:0]                    cap_ext;
  logic [EW-1:0]                    max_ext;
  logic [EW-1:0]                    count_ext;
  logic                             full;
  logic                             over;
  logic [2*FW-1:0]                  rd_data;
  logic [FW-1:0]                    rd_w;
  logic [FW-1:0]                    rd_h;
  logic                             pipe_occ;
  logic [SW-1:0]                    pipe_rank;
  sklru_pkg::cmp_req_t              cmp_req;
  logic                             cmp_flag;
  logic [SW-1:0]                    upd_slot;
  logic [SW-1:0]                    last_rank;
  logic                             mem_wr;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;

  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = paddr[sklru_pkg::APB_AW-1:2];
  // a capacity of zero is kept as one
  assign cap_wr_val = (pwdata[sklru_pkg::CAP_W-1:0] == '0) ?
                      sklru_pkg::CAP_W'(1) : pwdata[sklru_pkg::CAP_W-1:0];

  assign cap_ext   = EW'(cap_r);
  assign max_ext   = EW'(MAX_ENTRIES);
  assign eff_cap   = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign count_ext = EW'(count_r);
  assign full      = (count_ext >= eff_cap);
  assign over      = (count_ext > eff_cap);

  assign rd_w      = rd_data[2*FW-1:FW];
  assign rd_h      = rd_data[FW-1:0];
  assign pipe_occ  = occ_r[pipe_idx_r];
  assign pipe_rank = rank_r[pipe_idx_r];

  // hit keeps its slot, a full table reuses the oldest, else lowest free slot
  always_comb begin
    priority if (hit_r) begin
      upd_slot  = hit_slot_r;
      last_rank = SW'(count_r - CW'(1));
    end else if (full) begin
      upd_slot  = old_slot_r;
      last_rank = SW'(count_r - CW'(1));
    end else begin
      upd_slot  = free_slot_r;
      last_rank = count_r[SW-1:0];
    end
  end

  assign mem_wr = (state_r == S_UPDATE) && !hit_r;

  // operand select for the shared compare unit
  always_comb begin
    cmp_req.op  = sklru_pkg::OP_EQ;
    cmp_req.a_w = rd_w;
    cmp_req.a_h = rd_h;
    cmp_req.b_w = req_r.img_width;
    cmp_req.b_h = req_r.img_height;
    cmp_req.lim = radius_r;
    if (state_r == S_CHK_W) begin
      cmp_req.op  = sklru_pkg::OP_DEV;
      cmp_req.a_w = req_r.img_width;
      cmp_req.b_w = nom_w_r;
    end else if (state_r == S_CHK_H) begin
      cmp_req.op  = sklru_pkg::OP_DEV;
      cmp_req.a_w = req_r.img_height;
      cmp_req.b_w = nom_h_r;
    end
  end

  sklru_cmp_unit u_cmp (
    .req  (cmp_req),
    .flag (cmp_flag)
  );

  sklru_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (SW),
    .DW    (2 * FW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (upd_slot),
    .wr_data ({req_r.img_width, req_r.img_height}),
    .rd_addr (k_r[SW-1:0]),
    .rd_data (rd_data)
  );

  // register readback
  always_comb begin
    unique case (cfg_idx)
      sklru_pkg::REG_CHECK_ENABLE:   prdata = sklru_pkg::APB_DW'(check_en_r);
      sklru_pkg::REG_NOMINAL_WIDTH:  prdata = sklru_pkg::APB_DW'(nom_w_r);
      sklru_pkg::REG_NOMINAL_HEIGHT: prdata = sklru_pkg::APB_DW'(nom_h_r);
      sklru_pkg::REG_CORNER_RADIUS:  prdata = sklru_pkg::APB_DW'(radius_r);
      sklru_pkg::REG_CAPACITY:       prdata = sklru_pkg::APB_DW'(cap_r);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      count_r     <= '0;
      check_en_r  <= 1'b0;
      nom_w_r     <= sklru_pkg::NOMINAL_RST;
      nom_h_r     <= sklru_pkg::NOMINAL_RST;
      radius_r    <= sklru_pkg::RADIUS_RST;
      cap_r       <= sklru_pkg::CAPACITY_RST;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r        <= in_data;
            k_r          <= '0;
            pipe_vld_r   <= 1'b0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            free_slot_r  <= SW'(MAX_ENTRIES - 1);
            state_r      <= check_en_r ? S_CHK_W : S_WALK;
          end
        end

        S_CHK_W: begin
          if (cmp_flag) begin
            res_r   <= '0;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_CHK_H;
          end
        end

        S_CHK_H: begin
          if (cmp_flag) begin
            res_r   <= '0;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_WALK;
          end
        end

        // one slot per cycle; RAM data is registered, so it is checked in the cycle after its address
        S_WALK: begin
          if (k_r < KW'(MAX_ENTRIES)) begin
            k_r <= k_r + KW'(1);
          end
          pipe_vld_r <= (k_r < KW'(MAX_ENTRIES));
          pipe_idx_r <= k_r[SW-1:0];
          if (pipe_vld_r) begin
            if (pipe_occ && cmp_flag) begin
              hit_r      <= 1'b1;
              hit_slot_r <= pipe_idx_r;
              hit_rank_r <= pipe_rank;
            end
            if (pipe_occ && (pipe_rank == '0)) begin
              old_slot_r <= pipe_idx_r;
              old_w_r    <= rd_w;
              old_h_r    <= rd_h;
            end
            if (!pipe_occ && !free_found_r) begin
              free_found_r <= 1'b1;
              free_slot_r  <= pipe_idx_r;
            end
            if (pipe_idx_r == SW'(MAX_ENTRIES - 1)) begin
              state_r <= S_UPDATE;
            end
          end
        end

        S_UPDATE: begin
          for (int s = 0; s < MAX_ENTRIES; s++) begin
            if (hit_r) begin
              if (occ_r[s] && (rank_r[s] > hit_rank_r)) begin
                rank_r[s] <= rank_r[s] - SW'(1);
              end
            end else if (full) begin
              if (occ_r[s]) begin
                rank_r[s] <= rank_r[s] - SW'(1);
              end
            end
          end
          rank_r[upd_slot] <= last_rank;
          if (!hit_r && !full) begin
            occ_r[upd_slot] <= 1'b1;
            count_r         <= count_r + CW'(1);
          end
          res_r.accepted       <= 1'b1;
          res_r.hit            <= hit_r;
          res_r.slot           <= sklru_pkg::SLOT_W'(upd_slot);
          res_r.evicted        <= !hit_r && full;
          res_r.evicted_width  <= (!hit_r && full) ? old_w_r : '0;
          res_r.evicted_height <= (!hit_r && full) ? old_h_r : '0;
          state_r              <= S_RESULT;
        end

        S_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        // drop the oldest entry each cycle until the count fits
        S_TRIM: begin
          if (over) begin
            for (int s = 0; s < MAX_ENTRIES; s++) begin
              if (occ_r[s]) begin
                if (rank_r[s] == '0) begin
                  occ_r[s] <= 1'b0;
                end else begin
                  rank_r[s] <= rank_r[s] - SW'(1);
                end
              end
            end
            count_r <= count_r - CW'(1);
          end else begin
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      // register writes arrive only while idle: the user must keep to this, the block itself does not enforce it
      if (cfg_wr) begin
        unique case (cfg_idx)
          sklru_pkg::REG_CHECK_ENABLE: begin
            if (check_en_r != pwdata[0]) begin
              check_en_r <= pwdata[0];
              occ_r      <= '0;
              count_r    <= '0;
            end
          end
          sklru_pkg::REG_NOMINAL_WIDTH: begin
            if (nom_w_r != pwdata[FW-1:0]) begin
              nom_w_r <= pwdata[FW-1:0];
              occ_r   <= '0;
              count_r <= '0;
            end
          end
          sklru_pkg::REG_NOMINAL_HEIGHT: begin
            if (nom_h_r != pwdata[FW-1:0]) begin
              nom_h_r <= pwdata[FW-1:0];
              occ_r   <= '0;
              count_r <= '0;
            end
          end
          sklru_pkg::REG_CORNER_RADIUS: begin
            if (radius_r != pwdata[FW-1:0]) begin
              radius_r <= pwdata[FW-1:0];
              occ_r    <= '0;
              count_r  <= '0;
            end
          end
          sklru_pkg::REG_CAPACITY: begin
            cap_r   <= cap_wr_val;
            state_r <= S_TRIM;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
